// ----- rtl/coe_pkg.sv -----
// Shared types and constants for the CoAP option encoder.
// Used by the front end, the job queue, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package coe_pkg;

   // Field widths of the request and response payloads.
   localparam int unsigned ByteW = 8;
   localparam int unsigned NumW  = 16;

   // Depth of the queue between the front end and the back end.
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueueAw    = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = QueueAw + 1;

   // A header expands to at most five bytes: nibble byte, two delta and two length bytes.
   localparam int unsigned JobBytes = 5;
   localparam int unsigned JobIdxW  = $clog2(JobBytes);

   // Option delta and length extension thresholds and nibble codes.
   localparam logic [NumW-1:0] Ext8Base    = NumW'(13);
   localparam logic [NumW-1:0] Ext16Base   = NumW'(269);
   localparam logic [3:0]      Ext8Nibble  = 4'd13;
   localparam logic [3:0]      Ext16Nibble = 4'd14;

   // Request commands.
   typedef enum logic [1:0] {
      CmdStart  = 2'd0,
      CmdHeader = 2'd1,
      CmdValue  = 2'd2,
      CmdUnused = 2'd3
   } cmd_type;

   // Kind of work handed from the front end to the back end.
   typedef enum logic [1:0] {
      KindHeader = 2'd0,
      KindValue  = 2'd1,
      KindError  = 2'd2
   } kind_type;

   // One queued job.
   typedef struct packed {
      kind_type              kind;
      logic [NumW-1:0]       delta;
      logic [NumW-1:0]       length;
      logic [ByteW-1:0]      data;
      logic                  last;
   } entry_type;

endpackage : coe_pkg

`default_nettype wire

// ----- rtl/coe_front.sv -----
// Front end of the CoAP option encoder: accepts requests, tracks the option
// number and value count, and queues classified jobs. Depends on coe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module coe_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [39:0]            req_tdata,  // option_number, value_length, value_byte
   input  wire logic [1:0]             req_tuser,  // command
   output logic                        push,
   output coe_pkg::entry_type          push_entry,
   input  wire logic                   queue_full
);
   import coe_pkg::*;

   logic [NumW-1:0]  prior_ff, prior_in;
   logic [NumW-1:0]  remain_ff, remain_in;
   cmd_type          cmd;
   logic [NumW-1:0]  num;
   logic [NumW-1:0]  len;
   logic [ByteW-1:0] vbyte;
   logic             accept;

   // Unpack the request.
   assign cmd    = cmd_type'(req_tuser);
   assign num    = req_tdata[15:0];
   assign len    = req_tdata[31:16];
   assign vbyte  = req_tdata[39:32];

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // Classify the request and work out the state that it leaves behind.
   always_comb begin
      prior_in          = prior_ff;
      remain_in         = remain_ff;
      push              = 1'b0;
      push_entry.kind   = KindError;
      push_entry.delta  = num - prior_ff;
      push_entry.length = len;
      push_entry.data   = vbyte;
      push_entry.last   = 1'b1;
      if (accept) begin
         unique case (cmd)
            CmdStart: begin
               prior_in  = '0;
               remain_in = '0;
            end
            CmdHeader: begin
               push = 1'b1;
               if (num >= prior_ff) begin
                  push_entry.kind = KindHeader;
                  prior_in        = num;
                  remain_in       = len;
               end
            end
            CmdValue: begin
               push = 1'b1;
               if (remain_ff != '0) begin
                  push_entry.kind = KindValue;
                  push_entry.last = (remain_ff == NumW'(1));
                  remain_in       = remain_ff - NumW'(1);
               end
            end
            CmdUnused: begin
            end
         endcase
      end
   end

   // Running option number and outstanding value count.
   always_ff @(posedge clock) begin
      if (reset) begin
         prior_ff  <= '0;
         remain_ff <= '0;
      end else begin
         prior_ff  <= prior_in;
         remain_ff <= remain_in;
      end
   end

endmodule : coe_front

`default_nettype wire

// ----- rtl/coe_queue.sv -----
// Short first-in first-out queue of jobs between the front and back ends.
// Depends on coe_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module coe_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire coe_pkg::entry_type push_entry,
   output logic                    full,
   input  wire logic               pop,
   output coe_pkg::entry_type      head,
   output logic                    empty
);
   import coe_pkg::*;

   entry_type            mem [QueueDepth];
   logic [QueueAw-1:0]   wr_ff, wr_in;
   logic [QueueAw-1:0]   rd_ff, rd_in;
   logic [QueueCntW-1:0] cnt_ff, cnt_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (cnt_ff == QueueCntW'(QueueDepth));
   assign empty   = (cnt_ff == '0);
   assign head    = mem[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_in  = do_push ? wr_ff + QueueAw'(1) : wr_ff;
      rd_in  = do_pop  ? rd_ff + QueueAw'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage is written at the tail.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_entry;
      end
   end

endmodule : coe_queue

`default_nettype wire

// ----- rtl/coe_back.sv -----
// Back end of the CoAP option encoder: expands queued jobs into header,
// extension and value bytes and drives the response register. Depends on coe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module coe_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire coe_pkg::entry_type head,
   input  wire logic               empty,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_tdata,  // out_byte
   output logic                    rsp_tlast,  // last
   output logic [0:0]              rsp_tuser   // error
);
   import coe_pkg::*;

   typedef struct packed {
      logic [3:0]       nib;
      logic [ByteW-1:0] ext0;
      logic [ByteW-1:0] ext1;
      logic [1:0]       n;
   } code_type;

   // Nibble code and extension bytes for an option delta or length.
   function automatic code_type field_code(input logic [NumW-1:0] x);
      code_type        c;
      logic [NumW-1:0] d8;
      logic [NumW-1:0] d16;
      d8     = x - Ext8Base;
      d16    = x - Ext16Base;
      c.ext0 = '0;
      c.ext1 = '0;
      if (x < Ext8Base) begin
         c.nib = x[3:0];
         c.n   = 2'd0;
      end else if (x < Ext16Base) begin
         c.nib  = Ext8Nibble;
         c.ext0 = d8[7:0];
         c.n    = 2'd1;
      end else begin
         c.nib  = Ext16Nibble;
         c.ext0 = d16[15:8];
         c.ext1 = d16[7:0];
         c.n    = 2'd2;
      end
      return c;
   endfunction

   code_type          dcode;
   code_type          lcode;
   logic [ByteW-1:0]  dext [2];
   logic [ByteW-1:0]  lext [2];
   logic [ByteW-1:0]  load_bytes [JobBytes];
   logic [JobIdxW-1:0] load_total;
   logic              load_last;
   logic              load_err;

   logic [ByteW-1:0]  job_bytes_ff [JobBytes];
   logic [JobIdxW-1:0] job_total_ff;
   logic              job_last_ff;
   logic              job_err_ff;
   logic              job_valid_ff, job_valid_in;
   logic [JobIdxW-1:0] job_idx_ff, job_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ByteW-1:0]  rsp_data_ff;
   logic              rsp_last_ff;
   logic              rsp_err_ff;

   logic              emit;
   logic              final_byte;

   // Lay out the bytes of the job at the head of the queue.
   always_comb begin
      dcode      = field_code(head.delta);
      lcode      = field_code(head.length);
      dext[0]    = dcode.ext0;
      dext[1]    = dcode.ext1;
      lext[0]    = lcode.ext0;
      lext[1]    = lcode.ext1;
      for (int i = 0; i < JobBytes; i++) begin
         load_bytes[i] = '0;
      end
      load_total = JobIdxW'(1);
      load_last  = 1'b1;
      load_err   = 1'b0;
      unique case (head.kind)
         KindHeader: begin
            load_bytes[0] = {dcode.nib, lcode.nib};
            for (int k = 0; k < 2; k++) begin
               if (2'(k) < dcode.n) begin
                  load_bytes[JobIdxW'(1 + k)] = dext[k];
               end
            end
            for (int k = 0; k < 2; k++) begin
               if (2'(k) < lcode.n) begin
                  load_bytes[JobIdxW'(1 + k) + JobIdxW'(dcode.n)] = lext[k];
               end
            end
            load_total = JobIdxW'(1) + JobIdxW'(dcode.n) + JobIdxW'(lcode.n);
         end
         KindValue: begin
            load_bytes[0] = head.data;
            load_last     = head.last;
         end
         default: begin
            load_err = 1'b1;
         end
      endcase
   end

   // Emit one byte a cycle whenever the response register is free or draining.
   assign emit       = job_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign final_byte = (job_idx_ff == job_total_ff - JobIdxW'(1));
   assign pop        = !empty && (!job_valid_ff || (emit && final_byte));

   // Job and response control.
   always_comb begin
      job_valid_in = job_valid_ff;
      job_idx_in   = job_idx_ff;
      if (pop) begin
         job_valid_in = 1'b1;
         job_idx_in   = '0;
      end else if (emit && final_byte) begin
         job_valid_in = 1'b0;
      end else if (emit) begin
         job_idx_in = job_idx_ff + JobIdxW'(1);
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         job_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         job_idx_ff   <= job_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Job and response payload.
   always_ff @(posedge clock) begin
      if (pop) begin
         job_bytes_ff <= load_bytes;
         job_total_ff <= load_total;
         job_last_ff  <= load_last;
         job_err_ff   <= load_err;
      end
      if (emit) begin
         rsp_data_ff <= job_bytes_ff[job_idx_ff];
         rsp_last_ff <= final_byte && job_last_ff;
         rsp_err_ff  <= job_err_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_err_ff;

endmodule : coe_back

`default_nettype wire

// ----- rtl/coap_option_encoder_core.sv -----
// CoAP option encoder (RFC 7252 option delta and length encoding), top level.
// Ties together coe_front, coe_queue and coe_back; depends on coe_pkg.
//
// A request is taken every cycle while the four-entry job queue has room.
// Start-message and unused commands produce nothing; every other request
// produces one job. Value bytes and error responses leave at one per cycle
// while the receiver is ready. A header produces one to five bytes (nibble
// byte, zero to two delta bytes, zero to two length bytes) at one byte per
// cycle from the back end, so long headers hold the queue and stall requests
// only once it fills. A request passes through the job queue, the job
// register and the response register before its response is valid. The
// error flag marks a decreasing option number or a surplus value byte; such
// a response carries a zero byte with tlast set.
`timescale 1ns / 1ps
`default_nettype none

module coap_option_encoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // option_number, value_length, value_byte
   input  wire logic [1:0]  req_tuser,  // command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // out_byte
   output logic             rsp_tlast,  // last
   output logic [0:0]       rsp_tuser   // error
);
   import coe_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      pop;
   entry_type head;
   logic      queue_empty;

   // Request classification and option state.
   coe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   // Job queue between the two halves.
   coe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty)
   );

   // Byte expansion and response register.
   coe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (queue_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule : coap_option_encoder_core

`default_nettype wire

// ----- verif/coap_option_encoder_core_tb.sv -----
// Testbench for coap_option_encoder_core: directed and random option traffic with a
// self-contained encoder predictor and an in-order response checker.
// Depends on coe_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module coap_option_encoder_core_tb;
   import coe_pkg::*;

   // One expected response byte.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
   } enc_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // option_number, value_length, value_byte
   logic [1:0]  req_tuser = '0;   // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // out_byte
   logic        rsp_tlast;        // last
   logic [0:0]  rsp_tuser;        // error

   // Predictor state: mirrors the running option number and the value count.
   logic [15:0]  prior_num = '0;
   logic [15:0]  value_left = '0;
   enc_byte_type pending_bytes[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int requests_sent = 0;
   int fail_count = 0;
   logic rx_holding = 1'b0;
   event start_hold;

   coap_option_encoder_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Nibble code of a delta or length field.
   function automatic logic [3:0] field_nibble(input logic [15:0] x);
      if (x >= Ext16Base) return Ext16Nibble;
      if (x >= Ext8Base) return Ext8Nibble;
      return x[3:0];
   endfunction

   // Works out the response bytes of one accepted request and updates the state.
   function automatic void encode_request(input cmd_type cmd, input logic [15:0] num,
                                          input logic [15:0] len, input logic [7:0] vb);
      enc_byte_type hdr[$];
      logic [15:0]  fields[2];
      logic [15:0]  x;
      logic [15:0]  delta;
      case (cmd)
         CmdStart: begin
            prior_num = '0;
            value_left = '0;
         end
         CmdHeader: begin
            if (num < prior_num) begin
               pending_bytes.push_back('{data: 8'h00, last: 1'b1, err: 1'b1});
            end else begin
               delta = num - prior_num;
               hdr.push_back('{data: {field_nibble(delta), field_nibble(len)},
                               last: 1'b0, err: 1'b0});
               fields[0] = delta;
               fields[1] = len;
               // Extension bytes: delta first, then length, high byte first.
               for (int f = 0; f < 2; f++) begin
                  if (fields[f] >= Ext16Base) begin
                     x = fields[f] - Ext16Base;
                     hdr.push_back('{data: x[15:8], last: 1'b0, err: 1'b0});
                     hdr.push_back('{data: x[7:0], last: 1'b0, err: 1'b0});
                  end else if (fields[f] >= Ext8Base) begin
                     x = fields[f] - Ext8Base;
                     hdr.push_back('{data: x[7:0], last: 1'b0, err: 1'b0});
                  end
               end
               hdr[hdr.size() - 1].last = 1'b1;
               foreach (hdr[i]) pending_bytes.push_back(hdr[i]);
               prior_num = num;
               value_left = len;
            end
         end
         CmdValue: begin
            if (value_left == 0) begin
               pending_bytes.push_back('{data: 8'h00, last: 1'b1, err: 1'b1});
            end else begin
               value_left = value_left - 16'd1;
               pending_bytes.push_back('{data: vb, last: (value_left == 0), err: 1'b0});
            end
         end
         default: ;
      endcase
   endfunction

   // Offers one request, with random idle cycles first, and waits for acceptance.
   task automatic send_request(input cmd_type cmd, input logic [15:0] num,
                               input logic [15:0] len, input logic [7:0] vb);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         req_tdata = 40'({$urandom, $urandom});
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = cmd;
      req_tdata = {vb, len, num};
      do @(posedge clock); while (!req_tready);
      encode_request(cmd, num, len, vb);
      if (cmd != CmdUnused) requests_sent++;
   endtask

   // One message: a start, then options in non-decreasing order with their value bytes,
   // sprinkled with decreasing numbers, truncated values, surplus bytes and
   // unused commands.
   task automatic send_message();
      logic [16:0] num;
      logic [16:0] prev;
      logic [16:0] step;
      logic [15:0] len;
      int n_opts;
      int n_vals;
      int r;
      send_request(CmdStart, 16'($urandom), 16'($urandom), 8'($urandom));
      num = '0;
      n_opts = $urandom_range(1, 6);
      for (int i = 0; i < n_opts; i++) begin
         prev = num;
         r = $urandom_range(0, 99);
         if (r < 50) step = 17'($urandom_range(0, 12));
         else if (r < 75) step = 17'($urandom_range(13, 268));
         else if (r < 92) step = 17'($urandom_range(269, 1500));
         else step = 17'($urandom_range(269, 65535));
         if (num + step > 17'd65535) step = 17'd65535 - num;
         num = num + step;
         r = $urandom_range(0, 99);
         if (r < 60) len = 16'($urandom_range(0, 12));
         else if (r < 85) len = 16'($urandom_range(13, 40));
         else if (r < 95) len = 16'($urandom_range(41, 300));
         else len = 16'($urandom_range(269, 65535));
         // A number below the running one is refused and leaves the state alone.
         if (prev != 0 && $urandom_range(0, 99) < 5)
            send_request(CmdHeader, 16'($urandom_range(0, prev - 1)), 16'($urandom),
                         8'($urandom));
         send_request(CmdHeader, num[15:0], len, 8'($urandom));
         n_vals = len;
         if (len > 40 || $urandom_range(0, 99) < 8)
            n_vals = $urandom_range(0, (len > 8) ? 8 : len);
         for (int j = 0; j < n_vals; j++)
            send_request(CmdValue, 16'($urandom), 16'($urandom), 8'($urandom));
         if ($urandom_range(0, 99) < 6)
            send_request(CmdValue, 16'($urandom), 16'($urandom), 8'($urandom));
         if ($urandom_range(0, 99) < 4)
            send_request(CmdUnused, 16'($urandom), 16'($urandom), 8'($urandom));
      end
   endtask

   // Field extremes, every command and each corner case of the encoding.
   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_request(CmdStart, 16'd0, 16'd0, 8'd0);
      send_request(CmdHeader, 16'd0, 16'd0, 8'd0);         // delta and length zero
      send_request(CmdHeader, 16'd12, 16'd12, 8'd0);       // largest nibble values
      send_request(CmdHeader, 16'd25, 16'd13, 8'd0);       // smallest one-byte extension
      send_request(CmdHeader, 16'd293, 16'd268, 8'd0);     // largest one-byte extension
      send_request(CmdHeader, 16'd562, 16'd269, 8'd0);     // smallest two-byte extension
      send_request(CmdHeader, 16'hFFFF, 16'hFFFF, 8'd0);   // largest fields
      send_request(CmdHeader, 16'hFFFF, 16'd2, 8'd0);      // repeated option number
      send_request(CmdValue, 16'd0, 16'd0, 8'h00);
      send_request(CmdValue, 16'd0, 16'd0, 8'hFF);         // final value byte
      send_request(CmdValue, 16'd0, 16'd0, 8'hA5);         // surplus value byte
      send_request(CmdHeader, 16'd100, 16'd0, 8'd0);       // decreasing number
      send_request(CmdUnused, 16'hFFFF, 16'hFFFF, 8'hFF);  // ignored command
      send_request(CmdStart, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_request(CmdHeader, 16'hFFFF, 16'd1, 8'd0);      // largest delta from zero
      send_request(CmdValue, 16'd0, 16'd0, 8'h5A);
      send_request(CmdHeader, 16'hFFFF, 16'd3, 8'd0);
      send_request(CmdValue, 16'd0, 16'd0, 8'h11);
      send_request(CmdHeader, 16'hFFFF, 16'd0, 8'd0);      // header cuts the value short
      send_request(CmdValue, 16'd0, 16'd0, 8'h22);         // nothing left after zero length
      send_request(CmdHeader, 16'd7, 16'd4, 8'd0);
      send_request(CmdStart, 16'd0, 16'd0, 8'd0);          // start clears the value count
      send_request(CmdValue, 16'd0, 16'd0, 8'h33);
   endtask

   // Random messages under one idling pattern.
   task automatic test_random_traffic(input int s_idle, input int r_idle, input int n_reqs);
      int first;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      first = requests_sent;
      while (requests_sent - first < n_reqs) send_message();
   endtask

   // The receiver holds off for a long stretch while requests keep coming, so the
   // job queue fills and the request side stalls.
   task automatic test_backpressure();
      int first;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      first = requests_sent;
      -> start_hold;
      while (requests_sent - first < 40) send_message();
   endtask

   // Long receiver hold-off, counted here.
   initial forever begin
      @(start_hold);
      rx_holding = 1'b1;
      repeat (300) @(posedge clock);
      rx_holding = 1'b0;
   end

   // Receiver readiness.
   always @(negedge clock) begin
      if (rx_holding) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Compare each accepted response with the oldest expected byte.
   always @(posedge clock) begin
      enc_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected response: byte %h last %b error %b",
                        rsp_tdata, rsp_tlast, rsp_tuser[0]);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata !== want.data || rsp_tlast !== want.last ||
                rsp_tuser[0] !== want.err) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: expected byte %h last %b error %b, got %h %b %b",
                           want.data, want.last, want.err,
                           rsp_tdata, rsp_tlast, rsp_tuser[0]);
            end
         end
      end
   end

   // Run limit.
   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

   // Test sequence.
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_traffic(6, 46, 130);
      test_random_traffic(46, 6, 130);
      test_backpressure();
      test_random_traffic(0, 0, 100);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
